// ----- hdl/priority_task_scheduler_macros.svh -----
// Assertion macros shared by the verification files of the task scheduler.
// No dependencies; include by bare file name.
`ifndef PRIORITY_TASK_SCHEDULER_MACROS_SVH
`define PRIORITY_TASK_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

// ----- hdl/pts_pkg.sv -----
// Types and codes shared by the priority task scheduler modules.
// No dependencies.
`timescale 1ns / 1ps

package pts_pkg;

  typedef enum logic [2:0] {
    OP_START    = 3'd0,
    OP_CREATE   = 3'd1,
    OP_DELAY    = 3'd2,
    OP_SUSPEND  = 3'd3,
    OP_ACTIVATE = 3'd4,
    OP_TICK     = 3'd5,
    OP_BAD      = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_READY     = 2'd0,
    ST_RUNNING   = 2'd1,
    ST_WAITING   = 2'd2,
    ST_SUSPENDED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_APPLY,
    BK_SCAN,
    BK_COMMIT,
    BK_REPORT
  } back_state_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [6:0]  priority_req;
    logic        autostart;
    logic [31:0] delay_ticks;
    logic [2:0]  target_task;
  } in_t;

  typedef struct packed {
    logic [2:0]  new_handle;
    logic        create_ok;
    logic        req_error;
    logic [2:0]  running_task;
    logic        running_valid;
    logic        switched;
    logic [31:0] tick_count;
  } out_t;

  // Decoded request as it travels from the front end to the executor.
  typedef struct packed {
    op_e         op;
    logic [6:0]  prio;
    logic        autostart;
    logic [31:0] delay;
    logic [2:0]  target;
  } cmd_t;

  // Handshake between the request queue and the executor.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

endpackage

// ----- hdl/pts_front.sv -----
// Front end: accepts request transactions, decodes them and queues them.
// Depends on pts_pkg.
`timescale 1ns / 1ps

module pts_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pts_pkg::in_t     in_data_i,
  output pts_pkg::cmd_req_t cmd_o,
  input  logic             cmd_pop_i
);
  import pts_pkg::*;

  localparam int unsigned Depth = 2;

  cmd_t       mem_q [Depth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push, pop;
  cmd_t       dec;

  always_comb begin
    unique case (in_data_i.req_type)
      OP_START:    dec.op = OP_START;
      OP_CREATE:   dec.op = OP_CREATE;
      OP_DELAY:    dec.op = OP_DELAY;
      OP_SUSPEND:  dec.op = OP_SUSPEND;
      OP_ACTIVATE: dec.op = OP_ACTIVATE;
      OP_TICK:     dec.op = OP_TICK;
      default:     dec.op = OP_BAD;
    endcase
    dec.prio      = in_data_i.priority_req;
    dec.autostart = in_data_i.autostart;
    dec.delay     = in_data_i.delay_ticks;
    dec.target    = in_data_i.target_task;
  end

  assign in_ready_o = (fill_q != 2'(Depth));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = cmd_pop_i && (fill_q != 2'd0);

  assign cmd_o.valid = (fill_q != 2'd0);
  assign cmd_o.cmd   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= dec;
    end
  end

endmodule

// ----- hdl/pts_back.sv -----
// Back end: holds the task table, executes requests with a sequential
// dispatch scan and registers the result. Depends on pts_pkg.
`timescale 1ns / 1ps

module pts_back #(
  parameter int unsigned MAX_TASKS  = 8,
  parameter int unsigned TICK_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pts_pkg::cmd_req_t cmd_i,
  output logic              cmd_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pts_pkg::out_t     out_data_o
);
  import pts_pkg::*;

  localparam int unsigned IdxW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CntW = $clog2(MAX_TASKS + 1);

  back_state_e state_q, state_d;
  cmd_t        cmd_q;
  logic [CntW-1:0] cnt_q;
  logic [IdxW-1:0] cur_q;
  logic            cur_vld_q;
  logic [TICK_WIDTH-1:0] ticks_q;

  logic [6:0]            prio_q  [MAX_TASKS];
  status_e               stat_q  [MAX_TASKS];
  logic [TICK_WIDTH-1:0] cdown_q [MAX_TASKS];

  logic [CntW-1:0] scan_q;
  logic            found_q;
  logic [6:0]      best_prio_q;
  logic [IdxW-1:0] best_idx_q;
  logic [IdxW-1:0] handle_q;
  logic            ok_q, err_q, sw_q;
  logic            out_vld_q;
  out_t            out_q;

  logic                  apply_err;
  logic                  do_switch;
  logic [IdxW-1:0]       scan_idx;
  logic                  scan_elig;
  logic                  out_load;
  status_e               commit_stat [MAX_TASKS];
  logic [TICK_WIDTH-1:0] commit_cd   [MAX_TASKS];
  logic [63:0]           ticks_wide;

  assign scan_idx  = scan_q[IdxW-1:0];
  // An empty table still passes through the scan state, which must find nothing.
  assign scan_elig = (scan_q < cnt_q) &&
                     ((stat_q[scan_idx] == ST_READY) || (stat_q[scan_idx] == ST_RUNNING));
  assign do_switch = found_q && !(cur_vld_q && (best_idx_q == cur_q));
  assign out_load  = (state_q == BK_REPORT) && (!out_vld_q || out_ready_i);

  always_comb begin
    unique case (cmd_q.op)
      OP_START, OP_CREATE: apply_err = (cnt_q >= CntW'(MAX_TASKS));
      OP_DELAY, OP_SUSPEND: apply_err = !cur_vld_q;
      OP_ACTIVATE: apply_err = (32'(cmd_q.target) >= 32'(cnt_q));
      OP_TICK: apply_err = 1'b0;
      default: apply_err = 1'b1;
    endcase
  end

  // Dispatch result and, on a tick, the countdown that follows it.
  always_comb begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      commit_stat[i] = stat_q[i];
      commit_cd[i]   = cdown_q[i];
      if (do_switch) begin
        if (IdxW'(i) == best_idx_q) begin
          commit_stat[i] = ST_RUNNING;
        end else if (cur_vld_q && (IdxW'(i) == cur_q) && (stat_q[i] == ST_RUNNING)) begin
          commit_stat[i] = ST_READY;
        end
      end
      if ((cmd_q.op == OP_TICK) && (32'(i) < 32'(cnt_q)) &&
          (commit_stat[i] == ST_WAITING)) begin
        commit_cd[i] = cdown_q[i] - TICK_WIDTH'(1);
        if (commit_cd[i] == '0) begin
          commit_stat[i] = ST_READY;
        end
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_i.valid) begin
          cmd_pop_o = 1'b1;
          state_d   = BK_APPLY;
        end
      end
      BK_APPLY: begin
        if (apply_err || (cmd_q.op == OP_CREATE)) begin
          state_d = BK_REPORT;
        end else begin
          state_d = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if ((scan_q + CntW'(1)) >= cnt_q) begin
          state_d = BK_COMMIT;
        end
      end
      BK_COMMIT: state_d = BK_REPORT;
      BK_REPORT: begin
        if (out_load) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control state of the scheduler.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      cur_q     <= '0;
      cur_vld_q <= 1'b0;
      ticks_q   <= '0;
      scan_q    <= '0;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
      ok_q      <= 1'b0;
      err_q     <= 1'b0;
      sw_q      <= 1'b0;
    end else begin
      if (state_q == BK_APPLY) begin
        ok_q    <= 1'b0;
        err_q   <= apply_err;
        sw_q    <= 1'b0;
        scan_q  <= '0;
        found_q <= 1'b0;
        if (!apply_err) begin
          unique case (cmd_q.op)
            OP_START: begin
              ticks_q   <= '0;
              cur_vld_q <= 1'b0;
              cnt_q     <= cnt_q + CntW'(1);
              ok_q      <= 1'b1;
            end
            OP_CREATE: begin
              cnt_q <= cnt_q + CntW'(1);
              ok_q  <= 1'b1;
            end
            OP_TICK: ticks_q <= ticks_q + TICK_WIDTH'(1);
            default: ;
          endcase
        end
      end
      if (state_q == BK_SCAN) begin
        scan_q <= scan_q + CntW'(1);
        if (scan_elig && (!found_q || (prio_q[scan_idx] > best_prio_q))) begin
          found_q <= 1'b1;
        end
      end
      if ((state_q == BK_COMMIT) && do_switch) begin
        cur_q     <= best_idx_q;
        cur_vld_q <= 1'b1;
        sw_q      <= 1'b1;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign ticks_wide = 64'(ticks_q);

  // Task table, scan payload and result register.
  always_ff @(posedge clk_i) begin
    if (state_q == BK_IDLE && cmd_i.valid) begin
      cmd_q <= cmd_i.cmd;
    end
    if (state_q == BK_APPLY) begin
      handle_q <= cnt_q[IdxW-1:0];
    end
    if ((state_q == BK_APPLY) && !apply_err) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        unique case (cmd_q.op)
          OP_START: begin
            if (32'(i) == 32'(cnt_q)) begin
              prio_q[i]  <= 7'd0;
              stat_q[i]  <= ST_READY;
              cdown_q[i] <= '0;
            end
          end
          OP_CREATE: begin
            if (32'(i) == 32'(cnt_q)) begin
              prio_q[i]  <= cmd_q.prio;
              stat_q[i]  <= cmd_q.autostart ? ST_READY : ST_SUSPENDED;
              cdown_q[i] <= '0;
            end
          end
          OP_DELAY: begin
            if (IdxW'(i) == cur_q) begin
              stat_q[i]  <= ST_WAITING;
              cdown_q[i] <= TICK_WIDTH'(cmd_q.delay);
            end
          end
          OP_SUSPEND: begin
            if (IdxW'(i) == cur_q) begin
              stat_q[i] <= ST_SUSPENDED;
            end
          end
          OP_ACTIVATE: begin
            if ((32'(i) == 32'(cmd_q.target)) && (stat_q[i] != ST_RUNNING)) begin
              stat_q[i] <= ST_READY;
            end
          end
          default: ;
        endcase
      end
    end
    if ((state_q == BK_SCAN) && scan_elig &&
        (!found_q || (prio_q[scan_idx] > best_prio_q))) begin
      best_prio_q <= prio_q[scan_idx];
      best_idx_q  <= scan_idx;
    end
    if (state_q == BK_COMMIT) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        stat_q[i]  <= commit_stat[i];
        cdown_q[i] <= commit_cd[i];
      end
    end
    if (out_load) begin
      out_q.new_handle    <= ok_q ? 3'(handle_q) : 3'd0;
      out_q.create_ok     <= ok_q;
      out_q.req_error     <= err_q;
      out_q.running_task  <= cur_vld_q ? 3'(cur_q) : 3'd0;
      out_q.running_valid <= cur_vld_q;
      out_q.switched      <= sw_q;
      out_q.tick_count    <= ticks_wide[31:0];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ----- hdl/priority_task_scheduler.sv -----
// Top level of the fixed-priority preemptive task scheduler.
// Depends on pts_pkg, pts_front and pts_back.
//
// Usage: requests enter on the in_valid_i / in_ready_o channel, one
// transaction per request, and each request yields exactly one result
// transaction on out_valid_o / out_ready_i, in order.
// A two-entry request queue separates the front end from the executor,
// so requests are taken while the executor is busy or a result waits.
// After acceptance, a request is fetched from the queue, applied,
// passed through the dispatch scan, one table entry per cycle,
// committed, and its result is registered. Create and rejected
// requests skip the scan and the commit. The executor takes the next
// request only once the result of the last one is registered.
// Reset clears the task count, current task and tick counter; table
// entries are written by start or create before they are read.
// A stalled receiver holds the result register; the executor then waits
// and the queue fills, after which in_ready_o drops.
`timescale 1ns / 1ps

module priority_task_scheduler #(
  parameter int unsigned MAX_TASKS  = 8,
  parameter int unsigned TICK_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pts_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pts_pkg::out_t out_data_o
);
  import pts_pkg::*;

  cmd_req_t cmd;
  logic     cmd_pop;

  pts_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  pts_back #(
    .MAX_TASKS  (MAX_TASKS),
    .TICK_WIDTH (TICK_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- hdl/pts_checker.sv -----
// Port-level checks for the task scheduler and the bind that attaches them.
// Depends on pts_pkg and priority_task_scheduler_macros.svh.
`timescale 1ns / 1ps
`include "priority_task_scheduler_macros.svh"

module pts_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input pts_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input pts_pkg::out_t out_data_o
);
  import pts_pkg::*;

  logic in_stall;
  logic out_stall;
  logic both_flags;
  logic out_sw;
  logic out_err;

  assign in_stall   = in_valid_i && !in_ready_o;
  assign out_stall  = out_valid_o && !out_ready_i;
  assign both_flags = out_data_o.create_ok && out_data_o.req_error;
  assign out_sw     = out_valid_o && out_data_o.switched;
  assign out_err    = out_valid_o && out_data_o.req_error;

  `PTS_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_stall, in_valid_i && $stable(in_data_i))
  `PTS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_data_o))
  `PTS_ASSERT_IMPLY(a_ok_err_excl, clk_i, rst_ni, out_valid_o, !both_flags)
  `PTS_ASSERT_IMPLY(a_switch_running, clk_i, rst_ni, out_sw, out_data_o.running_valid)
  `PTS_ASSERT_IMPLY(a_err_no_switch, clk_i, rst_ni, out_err, !out_data_o.switched)

endmodule

bind priority_task_scheduler pts_checker u_pts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ----- test/priority_task_scheduler_tb.sv -----
// Self-checking testbench for the priority task scheduler.
// Depends on pts_pkg and priority_task_scheduler; a built-in scheduler model
// predicts each result, and a monitor compares the outputs field by field.
`timescale 1ns / 1ps

module priority_task_scheduler_tb;
  import pts_pkg::*;

  localparam int unsigned NTASK = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  priority_task_scheduler uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Scheduler model state.
  int unsigned   m_count;
  logic [6:0]    m_prio [NTASK];
  status_e       m_stat [NTASK];
  logic [31:0]   m_cd   [NTASK];
  logic [2:0]    m_cur;
  logic          m_cur_v;
  logic [2:0]    m_chosen;
  logic [31:0]   m_ticks;

  out_t expected_results[$];
  int   error_count = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_cycles = 0;

  function automatic logic sched_dispatch();
    logic found;
    logic [6:0] best;
    found = 1'b0;
    best = '0;
    for (int i = 0; i < m_count; i++) begin
      if ((m_stat[i] == ST_READY || m_stat[i] == ST_RUNNING) &&
          (!found || m_prio[i] > best)) begin
        found = 1'b1;
        best = m_prio[i];
        m_chosen = i[2:0];
      end
    end
    if (!found) return 1'b0;
    if (m_cur_v && m_chosen == m_cur) return 1'b0;
    if (m_cur_v && m_stat[m_cur] == ST_RUNNING) m_stat[m_cur] = ST_READY;
    m_cur = m_chosen;
    m_cur_v = 1'b1;
    m_stat[m_cur] = ST_RUNNING;
    return 1'b1;
  endfunction

  function automatic out_t sched_predict(in_t rq);
    out_t r;
    r = '0;
    case (rq.req_type)
      OP_START: begin
        if (m_count >= NTASK) r.req_error = 1'b1;
        else begin
          m_ticks = '0;
          m_cur_v = 1'b0;
          m_prio[m_count] = '0;
          m_stat[m_count] = ST_READY;
          m_cd[m_count] = '0;
          r.new_handle = m_count[2:0];
          r.create_ok = 1'b1;
          m_count++;
          r.switched = sched_dispatch();
        end
      end
      OP_CREATE: begin
        if (m_count >= NTASK) r.req_error = 1'b1;
        else begin
          m_prio[m_count] = rq.priority_req;
          m_stat[m_count] = rq.autostart ? ST_READY : ST_SUSPENDED;
          m_cd[m_count] = '0;
          r.new_handle = m_count[2:0];
          r.create_ok = 1'b1;
          m_count++;
        end
      end
      OP_DELAY, OP_SUSPEND: begin
        if (!m_cur_v || m_cur >= m_count) r.req_error = 1'b1;
        else begin
          if (rq.req_type == OP_DELAY) begin
            m_stat[m_cur] = ST_WAITING;
            m_cd[m_cur] = rq.delay_ticks;
          end else m_stat[m_cur] = ST_SUSPENDED;
          r.switched = sched_dispatch();
        end
      end
      OP_ACTIVATE: begin
        if (rq.target_task >= m_count) r.req_error = 1'b1;
        else begin
          if (m_stat[rq.target_task] != ST_RUNNING) m_stat[rq.target_task] = ST_READY;
          r.switched = sched_dispatch();
        end
      end
      OP_TICK: begin
        m_ticks = m_ticks + 32'd1;
        r.switched = sched_dispatch();
        for (int i = 0; i < m_count; i++) begin
          if (m_stat[i] == ST_WAITING) begin
            m_cd[i] = m_cd[i] - 32'd1;
            if (m_cd[i] == '0) m_stat[i] = ST_READY;
          end
        end
      end
      default: r.req_error = 1'b1;
    endcase
    r.running_task = m_cur_v ? m_cur : 3'd0;
    r.running_valid = m_cur_v;
    r.tick_count = m_ticks;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Sends one request transaction and predicts its result on acceptance.
  // Valid stays high after acceptance so that requests can follow back to
  // back; an idle gap or wait_drained drops it.
  task automatic send_request(in_t rq);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= rq;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(sched_predict(rq));
  endtask

  function automatic in_t rand_request(logic [2:0] op);
    in_t rq;
    rq.req_type = op;
    rq.priority_req = 7'($urandom_range(127));
    rq.autostart = 1'($urandom_range(1));
    rq.delay_ticks = ($urandom_range(9) == 0) ? $urandom : $urandom_range(4);
    rq.target_task = 3'($urandom_range(7));
    return rq;
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Receiver side: random stalls and an optional long hold.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result checker.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) report_mismatch("unexpected result", 0, 0);
      else begin
        out_t w;
        w = expected_results.pop_front();
        if (out_data_o.new_handle !== w.new_handle)
          report_mismatch("new_handle", 32'(out_data_o.new_handle), 32'(w.new_handle));
        if (out_data_o.create_ok !== w.create_ok)
          report_mismatch("create_ok", 32'(out_data_o.create_ok), 32'(w.create_ok));
        if (out_data_o.req_error !== w.req_error)
          report_mismatch("req_error", 32'(out_data_o.req_error), 32'(w.req_error));
        if (out_data_o.running_task !== w.running_task)
          report_mismatch("running_task", 32'(out_data_o.running_task),
                          32'(w.running_task));
        if (out_data_o.running_valid !== w.running_valid)
          report_mismatch("running_valid", 32'(out_data_o.running_valid),
                          32'(w.running_valid));
        if (out_data_o.switched !== w.switched)
          report_mismatch("switched", 32'(out_data_o.switched), 32'(w.switched));
        if (out_data_o.tick_count !== w.tick_count)
          report_mismatch("tick_count", out_data_o.tick_count, w.tick_count);
      end
    end
  end

  task automatic test_empty_table();
    in_t rq;
    // With no tasks, every request sent here but tick is rejected.
    for (int op = 2; op < 8; op++) begin
      rq = rand_request(op[2:0]);
      send_request(rq);
    end
  endtask

  task automatic test_directed();
    in_t rq;
    rq = rand_request(OP_START);
    send_request(rq);
    rq = rand_request(OP_CREATE);
    rq.priority_req = 7'h7f; rq.autostart = 1'b0;
    send_request(rq);
    rq = rand_request(OP_CREATE);
    rq.priority_req = 7'h7f; rq.autostart = 1'b1;
    send_request(rq);
    rq = rand_request(OP_TICK);
    send_request(rq);
    rq = rand_request(OP_ACTIVATE); rq.target_task = 3'd1;
    send_request(rq);
    // Zero delay wraps the countdown, so the task stays waiting.
    rq = rand_request(OP_DELAY); rq.delay_ticks = '0;
    send_request(rq);
    rq = rand_request(OP_DELAY); rq.delay_ticks = 32'hffff_ffff;
    send_request(rq);
    rq = rand_request(OP_DELAY); rq.delay_ticks = 32'd1;
    send_request(rq);
    rq = rand_request(OP_TICK);
    send_request(rq);
    rq = rand_request(OP_SUSPEND);
    send_request(rq);
    rq = rand_request(OP_ACTIVATE); rq.target_task = 3'd7;
    send_request(rq);
    rq = rand_request(OP_BAD);
    send_request(rq);
    rq = rand_request(3'd6);
    send_request(rq);
    // Fill the table, then overflow it with create and start.
    for (int i = 0; i < 6; i++) begin
      rq = rand_request(OP_CREATE);
      rq.priority_req = (i == 0) ? 7'h00 : rq.priority_req;
      send_request(rq);
    end
    rq = rand_request(OP_START);
    send_request(rq);
    rq = rand_request(OP_ACTIVATE); rq.target_task = 3'd7;
    send_request(rq);
    wait_drained();
  endtask

  // Restarting from reset is not possible, so scenarios run against a
  // table that fills quickly; the random mix keeps operating on full tables.
  task automatic test_random(int n);
    in_t rq;
    int  pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 30) rq = rand_request(OP_TICK);
      else if (pick < 50) rq = rand_request(OP_ACTIVATE);
      else if (pick < 65) rq = rand_request(OP_DELAY);
      else if (pick < 78) rq = rand_request(OP_SUSPEND);
      else if (pick < 88) rq = rand_request(OP_CREATE);
      else if (pick < 96) rq = rand_request(OP_START);
      else rq = rand_request(3'($urandom_range(7)));
      send_request(rq);
    end
  endtask

  task automatic test_backpressure();
    in_t rq;
    hold_cycles = 300;
    for (int k = 0; k < 12; k++) begin
      rq = rand_request(OP_TICK);
      send_request(rq);
    end
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_directed();
    send_idle_pct = 35; recv_idle_pct = 60;
    test_random(500);
    test_backpressure();
    send_idle_pct = 60; recv_idle_pct = 35;
    test_random(500);
    wait_drained();
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(500);
    wait_drained();
    repeat (30) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0)
      $display("priority_task_scheduler_tb: clean");
    else
      $display("priority_task_scheduler_tb: errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("priority_task_scheduler_tb: errors");
    $finish;
  end

endmodule
